// ----- src/qalu_pkg.sv -----
// ----------------------------------------------------------------------------
// qalu_pkg: shared types and constants for the 32.32 fixed-point ALU
// Operation codes, special raw values and the parameter default.
// ----------------------------------------------------------------------------
package qalu_pkg;

  localparam int unsigned MaxExponentDefault = 64;

  typedef enum logic [4:0] {
    OpNeg  = 5'd0,  OpLnot = 5'd1,  OpBnot = 5'd2,  OpPow  = 5'd3,
    OpDiv  = 5'd4,  OpMul  = 5'd5,  OpRem  = 5'd6,  OpAdd  = 5'd7,
    OpSub  = 5'd8,  OpShl  = 5'd9,  OpShr  = 5'd10, OpLt   = 5'd11,
    OpLe   = 5'd12, OpGt   = 5'd13, OpGe   = 5'd14, OpEq   = 5'd15,
    OpNe   = 5'd16, OpAnd  = 5'd17, OpOr   = 5'd18, OpXor  = 5'd19,
    OpLand = 5'd20, OpLor  = 5'd21
  } op_e;

  localparam logic [63:0] QOne   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] QNan   = 64'd1;
  localparam logic [63:0] QInf   = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] QTrue  = 64'd16;

endpackage

// ----- src/q32_32_fixed_point_alu_top.sv -----
// ----------------------------------------------------------------------------
// q32_32_fixed_point_alu_top: iterative 32.32 fixed-point ALU
// One item in, one result item out; long operations run on shared units.
// ----------------------------------------------------------------------------
// Simple operations (add, logic, compares, shifts, unknown codes, divide by
// zero, power overflow) finish in the decode state. Multiply runs decode,
// then the three 32x32 partial products on one shared multiplier. Divide
// uses a restoring divider, one quotient bit a cycle. It first scans the
// trailing zeros of b, one per cycle; there are at most 63 of them.
// Remainder skips that scan. Power with exponent e >= 1 runs one multiply
// per extra factor; a negative exponent adds a full divide unless the
// product is zero. Exponent 0 goes straight to the result if it is positive
// and runs a divide if it is negative. The block takes one item at a time:
// in_stall_o is high until the result item has been taken, and then the
// block returns to idle, where the next item can be accepted.
module q32_32_fixed_point_alu_top #(
  parameter int unsigned MAX_EXPONENT = qalu_pkg::MaxExponentDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  kind_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] value_o,
  output logic        exponent_overflow_o
);
  import qalu_pkg::*;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StDec   = 8'b0000_0010,
    StMul   = 8'b0000_0100,
    StTz    = 8'b0000_1000,
    StDiv   = 8'b0001_0000,
    StPost  = 8'b0010_0000,
    StPowNx = 8'b0100_0000,
    StOut   = 8'b1000_0000
  } state_e;

  localparam int unsigned EW = $clog2(MAX_EXPONENT + 1) + 1;

  state_e state_q, state_d;
  logic [4:0]  kind_q;
  logic [63:0] a_q, b_q;
  logic [63:0] res_q, res_d;
  logic        ovf_q, ovf_d;
  // multiply
  logic [1:0]  mstep_q, mstep_d;
  logic [63:0] macc_q, macc_d, mx_q, mx_d, my_q, my_d;
  // divide
  logic [63:0] dn_q, dn_d, dd_q, dd_d, quo_q, quo_d;
  logic [63:0] rem_q, rem_d;
  logic [6:0]  cnt_q, cnt_d, tz_q, tz_d;
  logic        isrem_q, isrem_d;
  // power
  logic [EW-1:0] pcnt_q, pcnt_d;
  logic          pneg_q, pneg_d;

  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;
  logic [64:0] rsh, rsub;
  logic [63:0] bmag;
  logic [31:0] ebits;

  assign bmag  = b_q[63] ? (64'd0 - b_q) : b_q;
  assign ebits = bmag[63:32];

  // shared multiplier: step 0 ai*bi, 1 ai*bf, 2 af*bi
  always_comb begin
    mul_x = mx_q[63:32];
    mul_y = my_q[63:32];
    case (mstep_q)
      2'd1:    begin mul_x = mx_q[63:32]; mul_y = my_q[31:0]; end
      2'd2:    begin mul_x = mx_q[31:0];  mul_y = my_q[63:32]; end
      default: begin mul_x = mx_q[63:32]; mul_y = my_q[63:32]; end
    endcase
  end
  assign mul_p = mul_x * mul_y;

  assign rsh  = {rem_q, dn_q[63]};
  assign rsub = rsh - {1'b0, dd_q};

  always_comb begin
    state_d = state_q;
    res_d = res_q;  ovf_d = ovf_q;
    mstep_d = mstep_q; macc_d = macc_q; mx_d = mx_q; my_d = my_q;
    dn_d = dn_q; dd_d = dd_q; quo_d = quo_q; rem_d = rem_q;
    cnt_d = cnt_q; tz_d = tz_q; isrem_d = isrem_q;
    pcnt_d = pcnt_q; pneg_d = pneg_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StDec;
      StDec: begin
        ovf_d = 1'b0;
        res_d = QNan;
        state_d = StOut;
        case (kind_q)
          OpNeg:  res_d = 64'd0 - a_q;
          OpLnot: res_d = (a_q == 64'd0) ? 64'd1 : 64'd0;
          OpBnot: res_d = ~a_q;
          OpAdd:  res_d = a_q + b_q;
          OpSub:  res_d = a_q - b_q;
          OpShl:  res_d = (b_q[63:38] != 26'd0) ? 64'd0 : a_q << b_q[37:32];
          OpShr:  res_d = (b_q[63:38] != 26'd0) ? 64'd0 : a_q >> b_q[37:32];
          OpLt:   res_d = (a_q <  b_q) ? QTrue : 64'd0;
          OpLe:   res_d = (a_q <= b_q) ? QTrue : 64'd0;
          OpGt:   res_d = (a_q >  b_q) ? QTrue : 64'd0;
          OpGe:   res_d = (a_q >= b_q) ? QTrue : 64'd0;
          OpEq:   res_d = (a_q == b_q) ? QTrue : 64'd0;
          OpNe:   res_d = (a_q != b_q) ? QTrue : 64'd0;
          OpAnd:  res_d = a_q & b_q;
          OpOr:   res_d = a_q | b_q;
          OpXor:  res_d = a_q ^ b_q;
          OpLand: res_d = (a_q != 64'd0 && b_q != 64'd0) ? b_q : 64'd0;
          OpLor:  res_d = (a_q != 64'd0 && a_q[31:0] != 32'd1) ? a_q : b_q;
          OpMul: begin
            mx_d = a_q; my_d = b_q; mstep_d = 2'd0; macc_d = 64'd0;
            pcnt_d = '0; pneg_d = 1'b0; state_d = StMul;
          end
          OpDiv: begin
            isrem_d = 1'b0;
            if (b_q == 64'd0) res_d = (a_q != 64'd0) ? QInf : QNan;
            else begin
              dn_d = a_q; dd_d = b_q; tz_d = 7'd0; state_d = StTz;
            end
          end
          OpRem: begin
            isrem_d = 1'b1;
            if (b_q[63:32] == 32'd0) res_d = QNan;
            else begin
              dn_d = {a_q[63:32], 32'd0}; dd_d = {b_q[63:32], 32'd0};
              rem_d = '0; quo_d = '0; cnt_d = 7'd0; state_d = StDiv;
            end
          end
          OpPow: begin
            pneg_d = b_q[63];
            if (ebits > 32'(MAX_EXPONENT)) begin
              ovf_d = 1'b1;
            end else if (ebits == 32'd0) begin
              res_d = QOne;
              if (b_q[63]) begin
                isrem_d = 1'b0; dn_d = QOne; dd_d = QOne; tz_d = 7'd0;
                state_d = StTz;
              end
            end else begin
              res_d = a_q;
              pcnt_d = EW'(ebits) - EW'(1);
              state_d = StPowNx;
            end
          end
          default: res_d = QNan;
        endcase
      end
      StPowNx: begin
        if (pcnt_q == '0) begin
          if (pneg_q) begin
            isrem_d = 1'b0;
            dn_d = QOne; dd_d = res_q; tz_d = 7'd0;
            state_d = (res_q == 64'd0) ? StOut : StTz;
            if (res_q == 64'd0) res_d = QInf;
          end else state_d = StOut;
        end else begin
          pcnt_d = pcnt_q - EW'(1);
          mx_d = res_q; my_d = a_q; mstep_d = 2'd0; macc_d = 64'd0;
          state_d = StMul;
        end
      end
      StMul: begin
        mstep_d = mstep_q + 2'd1;
        if (mstep_q == 2'd0) macc_d = {mul_p[31:0], 32'd0};
        else macc_d = macc_q + mul_p;
        if (mstep_q == 2'd2) begin
          res_d = macc_q + mul_p;
          state_d = (kind_q == OpPow) ? StPowNx : StOut;
        end
      end
      StTz: begin
        // one trailing zero dropped a cycle
        if (dd_q[0]) begin
          rem_d = '0; quo_d = '0; cnt_d = 7'd0; state_d = StDiv;
        end else begin
          dd_d = dd_q >> 1; tz_d = tz_q + 7'd1;
        end
      end
      StDiv: begin
        dn_d = dn_q << 1;
        // partial remainder stays below the divisor; bit 64 of rsub is the borrow
        if (rsub[64]) begin
          rem_d = rsh[63:0]; quo_d = {quo_q[62:0], 1'b0};
        end else begin
          rem_d = rsub[63:0]; quo_d = {quo_q[62:0], 1'b1};
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) state_d = StPost;
      end
      StPost: begin
        if (isrem_q) res_d = rem_q;
        else if (tz_q >= 7'd32) res_d = quo_q >> (tz_q - 7'd32);
        else res_d = quo_q << (7'd32 - tz_q);
        state_d = StOut;
      end
      StOut: if (!out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      kind_q <= kind_i; a_q <= operand_a_i; b_q <= operand_b_i;
    end
    res_q <= res_d; ovf_q <= ovf_d;
    mstep_q <= mstep_d; macc_q <= macc_d; mx_q <= mx_d; my_q <= my_d;
    dn_q <= dn_d; dd_q <= dd_d; quo_q <= quo_d; rem_q <= rem_d;
    cnt_q <= cnt_d; tz_q <= tz_d; isrem_q <= isrem_d;
    pcnt_q <= pcnt_d; pneg_q <= pneg_d;
  end

  assign in_stall_o          = (state_q != StIdle);
  assign out_valid_o         = (state_q == StOut);
  assign value_o             = res_q;
  assign exponent_overflow_o = ovf_q;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_ovf_pow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exponent_overflow_o |-> kind_q == OpPow && value_o == QNan)
    else $error("overflow flag outside power");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o))
    else $error("result lost under stall");

endmodule

// ----- sim/tb_q32_32_fixed_point_alu_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_q32_32_fixed_point_alu_top: self-checking bench for the 32.32 ALU
// Drives directed and random operations through the valid/stall handshake,
// predicts every result in the bench and checks each result item in order.
// ----------------------------------------------------------------------------

class alu_scoreboard;
  logic [63:0] want_value[$];
  logic        want_ovf[$];
  int          mismatches;
  int          errors;

  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    logic [63:0] ai, af, bi, bf, hi;
    ai = a >> 32; af = a & 64'hFFFF_FFFF;
    bi = b >> 32; bf = b & 64'hFFFF_FFFF;
    hi = ((ai * bi) & 64'hFFFF_FFFF) << 32;
    return hi + ai * bf + af * bi;
  endfunction

  function automatic logic [63:0] fx_div(logic [63:0] a, logic [63:0] b);
    int tz;
    logic [63:0] q;
    if (b == 0) return (a != 0) ? qalu_pkg::QInf : qalu_pkg::QNan;
    tz = 0;
    while (b[tz] == 1'b0) tz++;
    q = a / (b >> tz);
    if (tz >= 32) return q >> (tz - 32);
    return q << (32 - tz);
  endfunction

  function automatic void fx_pow(logic [63:0] a, logic [63:0] b,
                                 output logic [63:0] v, output logic ovf);
    logic [63:0] mag, e, acc;
    mag = b[63] ? -b : b;
    e = mag >> 32;
    ovf = 0;
    if (e > qalu_pkg::MaxExponentDefault) begin
      ovf = 1; v = qalu_pkg::QNan; return;
    end
    if (e == 0) acc = qalu_pkg::QOne;
    else begin
      acc = a;
      for (longint i = 1; i < e; i++) acc = fx_mul(acc, a);
    end
    v = b[63] ? fx_div(qalu_pkg::QOne, acc) : acc;
  endfunction

  function void note_item(logic [4:0] kind, logic [63:0] a, logic [63:0] b);
    logic [63:0] v, n, x, y;
    logic ovf;
    ovf = 0;
    n = b >> 32;
    case (kind)
      qalu_pkg::OpNeg:  v = -a;
      qalu_pkg::OpLnot: v = (a == 0) ? 64'd1 : 64'd0;
      qalu_pkg::OpBnot: v = ~a;
      qalu_pkg::OpPow:  fx_pow(a, b, v, ovf);
      qalu_pkg::OpDiv:  v = fx_div(a, b);
      qalu_pkg::OpMul:  v = fx_mul(a, b);
      qalu_pkg::OpRem: begin
        x = a & 64'hFFFF_FFFF_0000_0000; y = b & 64'hFFFF_FFFF_0000_0000;
        v = (y == 0) ? qalu_pkg::QNan : x % y;
      end
      qalu_pkg::OpAdd:  v = a + b;
      qalu_pkg::OpSub:  v = a - b;
      qalu_pkg::OpShl:  v = (n >= 64) ? 64'd0 : a << n;
      qalu_pkg::OpShr:  v = (n >= 64) ? 64'd0 : a >> n;
      qalu_pkg::OpLt:   v = (a < b) ? qalu_pkg::QTrue : 64'd0;
      qalu_pkg::OpLe:   v = (a <= b) ? qalu_pkg::QTrue : 64'd0;
      qalu_pkg::OpGt:   v = (a > b) ? qalu_pkg::QTrue : 64'd0;
      qalu_pkg::OpGe:   v = (a >= b) ? qalu_pkg::QTrue : 64'd0;
      qalu_pkg::OpEq:   v = (a == b) ? qalu_pkg::QTrue : 64'd0;
      qalu_pkg::OpNe:   v = (a != b) ? qalu_pkg::QTrue : 64'd0;
      qalu_pkg::OpAnd:  v = a & b;
      qalu_pkg::OpOr:   v = a | b;
      qalu_pkg::OpXor:  v = a ^ b;
      qalu_pkg::OpLand: v = (a != 0 && b != 0) ? b : 64'd0;
      qalu_pkg::OpLor:  v = (a != 0 && a[31:0] != 32'd1) ? a : b;
      default:          v = qalu_pkg::QNan;
    endcase
    want_value.push_back(v);
    want_ovf.push_back(ovf);
  endfunction

  function void check_result(logic [63:0] value, logic ovf);
    logic [63:0] ev;
    logic eo;
    if (want_value.size() == 0) begin
      errors++;
      if (mismatches++ < 10) $display("unexpected result item value=%h", value);
      return;
    end
    ev = want_value.pop_front();
    eo = want_ovf.pop_front();
    if (value !== ev || ovf !== eo) begin
      errors++;
      if (mismatches++ < 10)
        $display("mismatch: value exp %h got %h, ovf exp %b got %b", ev, value, eo, ovf);
    end
  endfunction
endclass

module tb_q32_32_fixed_point_alu_top;
  import qalu_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [4:0]  kind_i = '0;
  logic [63:0] operand_a_i = '0;
  logic [63:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [63:0] value_o;
  logic        exponent_overflow_o;

  alu_scoreboard results = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  q32_32_fixed_point_alu_top dut (.*);

  initial forever #4 clk_i = ~clk_i;

  // receiver side: random stall, check on each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      results.check_result(value_o, exponent_overflow_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return {$urandom_range(9), 32'd0};
      2: return {$urandom_range(3), $urandom};
      3: return -{$urandom_range(5), $urandom};
      4: return {$urandom, $urandom} >> $urandom_range(63);
      5: return 64'hFFFF_FFFF_FFFF_FFFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // valid drops only while idling, so back-to-back items drive it once a step
  task automatic send_item(logic [4:0] kind, logic [63:0] a, logic [63:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1;
    kind_i      <= kind;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    results.note_item(kind, a, b);
  endtask

  task automatic send_random();
    logic [4:0] k;
    logic [63:0] a, b;
    k = ($urandom_range(29) == 0) ? 5'($urandom_range(22, 31)) : 5'($urandom_range(21));
    a = pick_operand();
    b = pick_operand();
    if (k == OpPow) begin
      // mostly small exponents; big ones are slow
      b = {32'($urandom_range(70)), $urandom};
      if ($urandom_range(1)) b = -b;
      if ($urandom_range(3) == 0) a = {$urandom_range(2), $urandom};
    end else if (k == OpShl || k == OpShr) begin
      if ($urandom_range(3) != 0) b = {32'($urandom_range(70)), $urandom};
    end else if (k >= OpLt && k <= OpNe && $urandom_range(2) == 0) begin
      b = a;
    end
    send_item(k, a, b);
  endtask

  initial begin
    int pct[4][2] = '{'{0, 0}, '{50, 0}, '{0, 50}, '{22, 22}};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: every op at the extremes, then the special cases
    for (int k = 0; k <= 21; k++)
      send_item(5'(k), 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0002_8000_0000);
    send_item(OpDiv, 64'd0, 64'd0);
    send_item(OpDiv, 64'd5, 64'd0);
    send_item(OpRem, 64'h0000_0007_0000_0000, 64'h0000_0000_FFFF_FFFF);
    send_item(OpShl, 64'h1234, 64'h0000_0040_0000_0000);
    send_item(OpPow, 64'h0000_0002_0000_0000, 64'h0000_0000_8000_0000);
    send_item(OpPow, 64'h0000_0002_0000_0000, -64'h0000_0003_0000_0000);
    send_item(OpPow, 64'h0000_0002_0000_0000, 64'h0000_0041_0000_0000);
    send_item(OpLor, 64'h0000_0005_0000_0001, 64'h55);
    send_item(5'd31, 64'd0, 64'd0);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = pct[p][0];
      recv_stall_pct = pct[p][1];
      for (int i = 0; i < 275; i++) send_random();
    end
    send_idle_pct = 0;
    in_valid_i <= 0;

    while (results.want_value.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (results.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #40ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
